>>> rtl/wbbt_pkg.sv
// Shared types, constants and codes of the write-back buffer tracker.
`default_nettype none
package wbbt_pkg;

   localparam int NUM_BLOCKS_DEF  = 16;
   localparam int BLOCK_BYTES_DEF = 4096;
   localparam int NUM_PAGES_DEF   = 16;
   localparam int PAGE_BYTES_DEF  = 4096;

   localparam int ADDR_W   = 48;
   localparam int SIZE_W   = 21;
   localparam int LEN_W    = 17;
   localparam int ACTION_W = 3;
   localparam int KIND_W   = 2;

   localparam logic [ACTION_W-1:0] ACT_READ  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_INVAL = 3'd4;

   localparam logic [KIND_W-1:0] KIND_PAGE_READ = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EXTENT    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd2;

   localparam logic CSR_WB_ENABLE = 1'b0;
   localparam logic CSR_ASSIGNED  = 1'b1;

   // Classified command from the front part to the back part.
   typedef enum logic [2:0] {
      CMD_UNAVAIL,
      CMD_READ,
      CMD_WRITE,
      CMD_LOAD,
      CMD_FLUSH,
      CMD_INVAL
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [ADDR_W-1:0] offset;
      logic [SIZE_W-1:0] size;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_MID,
      ST_FLUSH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic              status;
      logic              last;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/wbbt_front.sv
// Front part: accepts request items, classifies them and queues them.
`default_nettype none
module wbbt_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [wbbt_pkg::ACTION_W-1:0] in_action,
   input  wire logic [wbbt_pkg::ADDR_W-1:0]  in_offset,
   input  wire logic [wbbt_pkg::SIZE_W-1:0]  in_size,
   output logic                              q_valid,
   input  wire logic                         q_ready,
   output wbbt_pkg::item_type                q_item
);
   // Two-entry queue.
   wbbt_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   wbbt_pkg::item_type item_in;

   always_comb begin
      item_in.offset = in_offset;
      item_in.size   = in_size;
      case (in_action)
         wbbt_pkg::ACT_READ:  item_in.cmd = wbbt_pkg::CMD_READ;
         wbbt_pkg::ACT_WRITE: item_in.cmd = wbbt_pkg::CMD_WRITE;
         wbbt_pkg::ACT_LOAD:  item_in.cmd = wbbt_pkg::CMD_LOAD;
         wbbt_pkg::ACT_FLUSH: item_in.cmd = wbbt_pkg::CMD_FLUSH;
         wbbt_pkg::ACT_INVAL: item_in.cmd = wbbt_pkg::CMD_INVAL;
         default:             item_in.cmd = wbbt_pkg::CMD_UNAVAIL;
      endcase
   end

   assign in_ready = (count_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign q_valid  = (count_ff != 2'd0);
   assign pop      = q_valid && q_ready;
   assign q_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

>>> rtl/wbbt_back.sv
// Back part: window state, page fetch walk, dirty-block flush walk.
`default_nettype none
module wbbt_back #(
   parameter int NUM_BLOCKS  = wbbt_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = wbbt_pkg::BLOCK_BYTES_DEF,
   parameter int NUM_PAGES   = wbbt_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES  = wbbt_pkg::PAGE_BYTES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wb_enable,
   input  wire logic               assigned,
   input  wire logic               q_valid,
   output logic                    q_ready,
   input  wire wbbt_pkg::item_type q_item,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output wbbt_pkg::result_type    out_result
);
   localparam int  AW  = wbbt_pkg::ADDR_W;
   localparam int  LW  = wbbt_pkg::LEN_W;
   localparam longint WIN = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
   localparam int  WINW = $clog2(WIN + 1);          // holds WIN itself
   localparam int  PGB  = $clog2(PAGE_BYTES);
   localparam int  BKB  = $clog2(BLOCK_BYTES);
   localparam int  PIW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int  BIW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int  PCW  = WINW - PGB + 1;           // page numbers within window end
   localparam int  BCW  = WINW - BKB + 1;
   localparam int  WSH  = $clog2(WIN);
   localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

   typedef logic [AW-1:0]   addr_t;
   typedef logic [WINW-1:0] win_t;

   wbbt_pkg::state_type state_ff, state_in;
   wbbt_pkg::item_type  cur_ff, cur_in;
   logic                win_valid_ff, win_valid_in;
   addr_t               base_ff, base_in;
   logic                any_dirty_ff, any_dirty_in;
   logic [NUM_BLOCKS-1:0] dirty_ff, dirty_in;
   logic [NUM_PAGES-1:0]  fetched_ff, fetched_in;
   win_t                rel_ff, rel_in, end_ff, end_in;
   logic [PCW-1:0]      sp_ff, sp_in, ep_ff, ep_in, pidx_ff, pidx_in;
   logic                end_al_ff, end_al_in;
   logic [BCW-1:0]      bidx_ff, bidx_in, rstart_ff, rstart_in;
   logic                in_run_ff, in_run_in;
   logic                done_status_ff, done_status_in;
   addr_t               done_addr_ff, done_addr_in;
   logic [LW-1:0]       done_len_ff, done_len_in;
   logic                ov_ff, ov_in;
   wbbt_pkg::result_type ores_ff, ores_in;

   // Request setup terms, computed from the queue head.
   addr_t        d_rel;
   logic         in_win;
   logic [AW:0]  d_end_full;
   win_t         d_end, d_acc;
   logic [PCW-1:0] d_ep_raw;
   logic         d_end_al;
   logic [BCW-1:0] b0, bstop;
   logic [NUM_BLOCKS-1:0] mark;
   logic         can_emit, is_write, dflag;

   assign d_rel      = q_item.offset - base_ff;
   assign in_win     = win_valid_ff && (q_item.offset >= base_ff) &&
                       (d_rel < addr_t'(WIN));
   assign d_end_full = {1'b0, d_rel} + {{(AW+1-wbbt_pkg::SIZE_W){1'b0}}, q_item.size};
   assign d_end      = (d_end_full > (AW+1)'(WIN)) ? win_t'(WIN) : win_t'(d_end_full);
   assign d_acc      = d_end - win_t'(d_rel);
   assign d_ep_raw   = PCW'(d_end >> PGB);
   assign d_end_al   = (d_end[PGB-1:0] == '0);

   // Block range of a write, from the saved relative start and end.
   assign b0    = BCW'(rel_ff >> BKB);
   assign bstop = BCW'(end_ff >> BKB) + BCW'(end_ff[BKB-1:0] != '0);
   always_comb begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         mark[b] = (BCW'(b) >= b0) && (BCW'(b) < bstop);
      end
   end

   assign can_emit = !ov_ff || out_ready;
   assign is_write = (cur_ff.cmd == wbbt_pkg::CMD_WRITE);
   assign dflag    = (bidx_ff < BCW'(NUM_BLOCKS)) && dirty_ff[bidx_ff[BIW-1:0]];

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      win_valid_in   = win_valid_ff;
      base_in        = base_ff;
      any_dirty_in   = any_dirty_ff;
      dirty_in       = dirty_ff;
      fetched_in     = fetched_ff;
      rel_in         = rel_ff;
      end_in         = end_ff;
      sp_in          = sp_ff;
      ep_in          = ep_ff;
      pidx_in        = pidx_ff;
      end_al_in      = end_al_ff;
      bidx_in        = bidx_ff;
      rstart_in      = rstart_ff;
      in_run_in      = in_run_ff;
      done_status_in = done_status_ff;
      done_addr_in   = done_addr_ff;
      done_len_in    = done_len_ff;
      ov_in          = ov_ff && !out_ready;
      ores_in        = ores_ff;
      q_ready        = 1'b0;

      case (state_ff)
         wbbt_pkg::ST_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               cur_in         = q_item;
               done_status_in = 1'b0;
               done_len_in    = '0;
               done_addr_in   = base_ff;
               case (q_item.cmd)
                  wbbt_pkg::CMD_READ, wbbt_pkg::CMD_WRITE: begin
                     done_addr_in = q_item.offset;
                     if (!in_win) begin
                        done_status_in = 1'b1;
                        state_in       = wbbt_pkg::ST_DONE;
                     end else begin
                        rel_in      = win_t'(d_rel);
                        end_in      = d_end;
                        end_al_in   = d_end_al;
                        sp_in       = PCW'(d_rel >> PGB);
                        ep_in       = d_end_al ? ((d_ep_raw != '0) ? d_ep_raw - 1'b1 : '0)
                                               : d_ep_raw;
                        done_len_in = (d_acc > win_t'(LEN_MAX)) ? LEN_MAX : LW'(d_acc);
                        state_in    = wbbt_pkg::ST_FIRST;
                     end
                  end
                  wbbt_pkg::CMD_LOAD: begin
                     win_valid_in = 1'b1;
                     base_in      = (q_item.offset >> WSH) << WSH;
                     done_addr_in = (q_item.offset >> WSH) << WSH;
                     any_dirty_in = 1'b0;
                     dirty_in     = '0;
                     fetched_in   = '0;
                     state_in     = wbbt_pkg::ST_DONE;
                  end
                  wbbt_pkg::CMD_FLUSH, wbbt_pkg::CMD_INVAL: begin
                     bidx_in   = '0;
                     in_run_in = 1'b0;
                     if (wb_enable && assigned && any_dirty_ff) begin
                        state_in = wbbt_pkg::ST_FLUSH;
                     end else begin
                        state_in = wbbt_pkg::ST_DONE;
                        if (q_item.cmd == wbbt_pkg::CMD_INVAL) begin
                           win_valid_in = 1'b0;
                           base_in      = '0;
                           done_addr_in = '0;
                           any_dirty_in = 1'b0;
                           dirty_in     = '0;
                           fetched_in   = '0;
                        end
                     end
                  end
                  default: begin
                     done_addr_in   = q_item.offset;
                     done_status_in = 1'b1;
                     state_in       = wbbt_pkg::ST_DONE;
                  end
               endcase
            end
         end

         // First page; a write that fully covers it from an aligned start skips the read.
         wbbt_pkg::ST_FIRST: begin
            if (can_emit) begin
               if (sp_ff < PCW'(NUM_PAGES) && !fetched_ff[sp_ff[PIW-1:0]]) begin
                  fetched_in[sp_ff[PIW-1:0]] = 1'b1;
                  if (!(is_write && rel_ff[PGB-1:0] == '0 &&
                        cur_ff.size >= wbbt_pkg::SIZE_W'(PAGE_BYTES))) begin
                     ov_in   = 1'b1;
                     ores_in = '{wbbt_pkg::KIND_PAGE_READ,
                                 base_ff + (AW'(sp_ff) << PGB), LW'(PAGE_BYTES), 1'b0, 1'b0};
                  end
               end
               pidx_in  = sp_ff + 1'b1;
               state_in = (ep_ff > sp_ff) ? wbbt_pkg::ST_LAST : wbbt_pkg::ST_DONE;
            end
         end

         wbbt_pkg::ST_LAST: begin
            if (can_emit) begin
               if (ep_ff < PCW'(NUM_PAGES) && !fetched_ff[ep_ff[PIW-1:0]]) begin
                  fetched_in[ep_ff[PIW-1:0]] = 1'b1;
                  if (!(is_write && end_al_ff)) begin
                     ov_in   = 1'b1;
                     ores_in = '{wbbt_pkg::KIND_PAGE_READ,
                                 base_ff + (AW'(ep_ff) << PGB), LW'(PAGE_BYTES), 1'b0, 1'b0};
                  end
               end
               state_in = wbbt_pkg::ST_MID;
            end
         end

         // Middle pages, one per cycle while no result is stalled.
         wbbt_pkg::ST_MID: begin
            if (can_emit) begin
               if (pidx_ff >= ep_ff) begin
                  state_in = wbbt_pkg::ST_DONE;
               end else begin
                  if (pidx_ff < PCW'(NUM_PAGES) && !fetched_ff[pidx_ff[PIW-1:0]]) begin
                     fetched_in[pidx_ff[PIW-1:0]] = 1'b1;
                     if (!is_write) begin
                        ov_in   = 1'b1;
                        ores_in = '{wbbt_pkg::KIND_PAGE_READ,
                                    base_ff + (AW'(pidx_ff) << PGB), LW'(PAGE_BYTES),
                                    1'b0, 1'b0};
                     end
                  end
                  pidx_in = pidx_ff + 1'b1;
               end
            end
         end

         // Walk dirty bits one block per cycle while no result is stalled, emit one extent per run.
         wbbt_pkg::ST_FLUSH: begin
            if (can_emit) begin
               bidx_in = bidx_ff + 1'b1;
               if (dflag) begin
                  if (!in_run_ff) begin
                     in_run_in = 1'b1;
                     rstart_in = bidx_ff;
                  end
                  dirty_in[bidx_ff[BIW-1:0]] = 1'b0;
               end else if (in_run_ff) begin
                  in_run_in = 1'b0;
                  ov_in     = 1'b1;
                  ores_in   = '{wbbt_pkg::KIND_EXTENT,
                                base_ff + (AW'(rstart_ff) << BKB),
                                LW'(32'(bidx_ff - rstart_ff) << BKB) |
                                (((32'(bidx_ff - rstart_ff) << BKB) > 32'(LEN_MAX))
                                 ? LEN_MAX : '0),
                                1'b0, 1'b0};
               end
               if (bidx_ff == BCW'(NUM_BLOCKS)) begin
                  any_dirty_in = 1'b0;
                  state_in     = wbbt_pkg::ST_DONE;
                  if (cur_ff.cmd == wbbt_pkg::CMD_INVAL) begin
                     win_valid_in = 1'b0;
                     base_in      = '0;
                     done_addr_in = '0;
                     dirty_in     = '0;
                     fetched_in   = '0;
                  end
               end
            end
         end

         wbbt_pkg::ST_DONE: begin
            if (can_emit) begin
               if (is_write && done_status_ff == 1'b0) begin
                  dirty_in     = dirty_ff | mark;
                  any_dirty_in = 1'b1;
               end
               ov_in    = 1'b1;
               ores_in  = '{wbbt_pkg::KIND_DONE, done_addr_ff, done_len_ff,
                            done_status_ff, 1'b1};
               state_in = wbbt_pkg::ST_IDLE;
            end
         end

         default: state_in = wbbt_pkg::ST_IDLE;
      endcase
   end

   assign out_valid  = ov_ff;
   assign out_result = ores_ff;

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rel_ff         <= rel_in;
      end_ff         <= end_in;
      sp_ff          <= sp_in;
      ep_ff          <= ep_in;
      pidx_ff        <= pidx_in;
      end_al_ff      <= end_al_in;
      bidx_ff        <= bidx_in;
      rstart_ff      <= rstart_in;
      in_run_ff      <= in_run_in;
      done_status_ff <= done_status_in;
      done_addr_ff   <= done_addr_in;
      done_len_ff    <= done_len_in;
      ores_ff        <= ores_in;
      if (reset) begin
         state_ff     <= wbbt_pkg::ST_IDLE;
         win_valid_ff <= 1'b0;
         base_ff      <= '0;
         any_dirty_ff <= 1'b0;
         dirty_ff     <= '0;
         fetched_ff   <= '0;
         ov_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_valid_ff <= win_valid_in;
         base_ff      <= base_in;
         any_dirty_ff <= any_dirty_in;
         dirty_ff     <= dirty_in;
         fetched_ff   <= fetched_in;
         ov_ff        <= ov_in;
      end
   end
endmodule
`default_nettype wire

>>> rtl/write_back_buffer_tracker_top.sv
// Top level of the write-back buffer tracker.
`default_nettype none
// Tracks one aligned window of NUM_BLOCKS*BLOCK_BYTES bytes: its base, a
// fetched bit per page and a dirty bit per block. Read and write transactions
// inside the window answer page-read requests for unfetched pages (first page,
// last page, then middle pages ascending; a write skips pages it fully
// overwrites) and one completion marked by tlast. Flush walks the dirty bits
// one block per cycle while no result is stalled and emits one write-back
// extent per dirty run. A stalled result holds the back part until it is
// taken. A two-entry queue sits between the classifying front and the
// executing back, and a result register holds each result until it is taken.
// Write csr_ registers only while idle.
module write_back_buffer_tracker_top #(
   parameter int NUM_BLOCKS  = wbbt_pkg::NUM_BLOCKS_DEF,
   parameter int BLOCK_BYTES = wbbt_pkg::BLOCK_BYTES_DEF,
   parameter int NUM_PAGES   = wbbt_pkg::NUM_PAGES_DEF,
   parameter int PAGE_BYTES  = wbbt_pkg::PAGE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic        csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // action[2:0], offset[50:3], size[71:51]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // kind[1:0], address[49:2], length[66:50],
                                         // status[67], zero fill
   output logic             rsp_tlast
);
   logic wb_enable_ff, assigned_ff;
   logic q_valid, q_ready;
   wbbt_pkg::item_type   q_item;
   wbbt_pkg::result_type res;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wb_enable_ff <= 1'b1;
         assigned_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            wbbt_pkg::CSR_WB_ENABLE: wb_enable_ff <= csr_wdata;
            wbbt_pkg::CSR_ASSIGNED:  assigned_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   wbbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tdata[2:0]),
      .in_offset (req_tdata[50:3]),
      .in_size   (req_tdata[71:51]),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   wbbt_back #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .NUM_PAGES   (NUM_PAGES),
      .PAGE_BYTES  (PAGE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .wb_enable  (wb_enable_ff),
      .assigned   (assigned_ff),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tdata = {4'b0, res.status, res.length, res.address, res.kind};
   assign rsp_tlast = res.last;
endmodule
`default_nettype wire
